[src/nat_type_probe_fsm_assert.svh]
// Assertion macros shared by the NAT type probe modules.
// Each macro checks on the rising edge of the given clock, off during reset.
`ifndef NAT_TYPE_PROBE_FSM_ASSERT_SVH
`define NAT_TYPE_PROBE_FSM_ASSERT_SVH

`ifndef SYNTHESIS
`define NTP_ASSERT_HOLDS(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define NTP_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define NTP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define NTP_ASSERT_HOLDS(lbl, clk, rst, expr, msg)
`define NTP_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define NTP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

[src/ntp_pkg.sv]
// Package for the NAT type probe block: item types, codes and result builders.
// No dependencies; used by the core, the result queue and the top level.
`timescale 1ns / 1ps
`default_nettype none

package ntp_pkg;

  localparam logic [2:0] RETRY_LIMIT = 3'd4;

  // event codes
  localparam logic [2:0] CMD_TICK_BINDING = 3'd0;
  localparam logic [2:0] CMD_TICK_RESEND  = 3'd1;
  localparam logic [2:0] CMD_TICK_RECHECK = 3'd2;
  localparam logic [2:0] CMD_RSP_BINDING  = 3'd3;
  localparam logic [2:0] CMD_RSP_SERVERB  = 3'd4;
  localparam logic [2:0] CMD_RSP_NAT1     = 3'd5;
  localparam logic [2:0] CMD_RSP_NAT4     = 3'd6;
  localparam logic [2:0] CMD_RSP_NAT2     = 3'd7;

  // result kinds
  localparam logic [1:0] KIND_REQUEST = 2'd0;
  localparam logic [1:0] KIND_REPORT  = 2'd1;
  localparam logic [1:0] KIND_NOTICE  = 2'd2;
  localparam logic [1:0] KIND_BINDING = 2'd3;

  // request types
  localparam logic [2:0] REQ_BINDING = 3'd0;
  localparam logic [2:0] REQ_SERVERB = 3'd1;
  localparam logic [2:0] REQ_NAT1    = 3'd2;
  localparam logic [2:0] REQ_NAT4    = 3'd3;
  localparam logic [2:0] REQ_NAT2    = 3'd4;

  // NAT types
  localparam logic [2:0] NAT_OPEN        = 3'd1;
  localparam logic [2:0] NAT_RESTRICTED  = 3'd2;
  localparam logic [2:0] NAT_PORT_RESTR  = 3'd3;
  localparam logic [2:0] NAT_SYMMETRIC   = 3'd4;
  localparam logic [2:0] NAT_BLOCKED     = 3'd5;
  localparam logic [2:0] NAT_UNKNOWN     = 3'd6;
  localparam logic [4:0] NAT_PORT_CHANGE = 5'd10;

  // configuration register indexes
  localparam logic CFG_SERVER_A_IP   = 1'b0;
  localparam logic CFG_SERVER_A_PORT = 1'b1;

  localparam int RESQ_DEPTH = 4;
  localparam int RESQ_AW    = $clog2(RESQ_DEPTH);
  localparam int RESQ_CW    = $clog2(RESQ_DEPTH + 1);

  typedef struct packed {
    logic [2:0]  cmd;
    logic        parse_ok;
    logic [31:0] src_ip;
    logic [15:0] src_port;
    logic [31:0] mapped_ip;
    logic [15:0] mapped_port;
    logic [31:0] peer_b_ip;
    logic [15:0] peer_b_port;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  request_type;
    logic [31:0] dest_ip;
    logic [15:0] dest_port;
    logic [4:0]  nat_code;
    logic [31:0] bind_ip;
    logic [15:0] bind_port;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [1:0] n;
    out_item_t  item0;
    out_item_t  item1;
  } push_t;

  function automatic out_item_t mk_request(logic [2:0] rtype, logic [31:0] ip,
                                           logic [15:0] port);
    out_item_t r;
    r = '0;
    r.kind = KIND_REQUEST;
    r.request_type = rtype;
    r.dest_ip = ip;
    r.dest_port = port;
    return r;
  endfunction

  function automatic out_item_t mk_report(logic [4:0] code, logic [31:0] ip,
                                          logic [15:0] port);
    out_item_t r;
    r = '0;
    r.kind = KIND_REPORT;
    r.dest_ip = ip;
    r.dest_port = port;
    r.nat_code = code;
    return r;
  endfunction

  function automatic out_item_t mk_notice(logic [4:0] code);
    out_item_t r;
    r = '0;
    r.kind = KIND_NOTICE;
    r.nat_code = code;
    return r;
  endfunction

  function automatic out_item_t mk_binding(logic [31:0] ip, logic [15:0] port);
    out_item_t r;
    r = '0;
    r.kind = KIND_BINDING;
    r.bind_ip = ip;
    r.bind_port = port;
    return r;
  endfunction

endpackage

`default_nettype wire

[src/ntp_if.sv]
// Valid/ready channel interfaces for the NAT type probe block.
// ntp_evt_if carries event items in, ntp_res_if carries result items out.
`timescale 1ns / 1ps
`default_nettype none

interface ntp_evt_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic        parse_ok;
  logic [31:0] src_ip;
  logic [15:0] src_port;
  logic [31:0] mapped_ip;
  logic [15:0] mapped_port;
  logic [31:0] peer_b_ip;
  logic [15:0] peer_b_port;

  modport source (output valid, cmd, parse_ok, src_ip, src_port, mapped_ip, mapped_port,
                  peer_b_ip, peer_b_port, input ready);
  modport sink (input valid, cmd, parse_ok, src_ip, src_port, mapped_ip, mapped_port,
                peer_b_ip, peer_b_port, output ready);
endinterface

interface ntp_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  request_type;
  logic [31:0] dest_ip;
  logic [15:0] dest_port;
  logic [4:0]  nat_code;
  logic [31:0] bind_ip;
  logic [15:0] bind_port;
  logic        last;

  modport source (output valid, kind, request_type, dest_ip, dest_port, nat_code, bind_ip,
                  bind_port, last, input ready);
  modport sink (input valid, kind, request_type, dest_ip, dest_port, nat_code, bind_ip,
                bind_port, last, output ready);
endinterface

`default_nettype wire

[src/nat_type_probe_fsm.sv]
// NAT type probe block, top level.
// evt (sink): one event item per handshake: a timer tick or a decoded server
//   response with its source and reported addresses.
// res (source): result items in order: probe requests, NAT-type notices and
//   reports, binding-change notices; last marks the final item of an event.
// cfg_we/cfg_index/cfg_data: write port for server A address (index 0) and
//   port (index 1); user writes only while no event is in flight, unchecked.
// Flow: an accepted event is held in the input register; the decision logic
//   is combinational and pushes its results into the queue, read out on res.
// Throughput: one event per cycle into the input register while not stalled;
//   results leave at one per cycle while res is taken. A four-entry result
//   queue absorbs the difference.
// Stall: while res is not taken the queue fills; an event advances only when
//   two queue entries are free, and evt.ready falls once the input register
//   holds an event that cannot advance.
// Reset (rst, synchronous): probe starts in server-B discovery with NAT type
//   unknown, all captured addresses zero, the queue empty.
`timescale 1ns / 1ps
`default_nettype none

module nat_type_probe_fsm (
  input  wire logic        clk,
  input  wire logic        rst,
  ntp_evt_if.sink          evt,
  ntp_res_if.source        res,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);
  import ntp_pkg::*;

  logic [31:0] server_a_ip;
  logic [15:0] server_a_port;
  logic        room;
  push_t       push;

  always_ff @(posedge clk) begin
    if (rst) begin
      server_a_ip   <= '0;
      server_a_port <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SERVER_A_IP:   server_a_ip   <= cfg_data;
        CFG_SERVER_A_PORT: server_a_port <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  ntp_core u_core (
    .clk           (clk),
    .rst           (rst),
    .evt           (evt),
    .server_a_ip   (server_a_ip),
    .server_a_port (server_a_port),
    .room          (room),
    .push          (push)
  );

  ntp_resq u_resq (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .room (room),
    .res  (res)
  );

endmodule

`default_nettype wire

[src/ntp_core.sv]
// Probe engine: event input register, probe state and the per-event decision logic.
// Depends on ntp_pkg, ntp_if and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "nat_type_probe_fsm_assert.svh"

module ntp_core (
  input  wire logic          clk,
  input  wire logic          rst,
  ntp_evt_if.sink            evt,
  input  wire logic [31:0]   server_a_ip,
  input  wire logic [15:0]   server_a_port,
  input  wire logic          room,
  output ntp_pkg::push_t     push
);
  import ntp_pkg::*;

  localparam logic [2:0] PH_SERVERB = 3'd0;
  localparam logic [2:0] PH_NAT1    = 3'd1;
  localparam logic [2:0] PH_NAT4    = 3'd2;
  localparam logic [2:0] PH_NAT2    = 3'd3;
  localparam logic [2:0] PH_DONE    = 3'd4;

  logic        s1_valid;
  in_item_t    s1;
  logic        fire;
  logic        accept;

  logic [2:0]  phase, phase_next;
  logic [2:0]  retry_count, retry_count_next;
  logic [2:0]  nat_kind, nat_kind_next;
  logic [31:0] binding_ip, binding_ip_next;
  logic [15:0] binding_port, binding_port_next;
  logic [31:0] server_b_ip, server_b_ip_next;
  logic [15:0] server_b_port, server_b_port_next;
  logic [15:0] dual_port_a, dual_port_a_next;
  logic [15:0] dual_port_b, dual_port_b_next;

  assign fire       = s1_valid && room;
  assign evt.ready  = !s1_valid || room;
  assign accept     = evt.valid && evt.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.cmd         <= evt.cmd;
      s1.parse_ok    <= evt.parse_ok;
      s1.src_ip      <= evt.src_ip;
      s1.src_port    <= evt.src_port;
      s1.mapped_ip   <= evt.mapped_ip;
      s1.mapped_port <= evt.mapped_port;
      s1.peer_b_ip   <= evt.peer_b_ip;
      s1.peer_b_port <= evt.peer_b_port;
    end
  end

  always_comb begin
    logic       settle_req;
    logic [2:0] settle_t;
    logic [2:0] rs_phase;
    logic [2:0] rs_cnt;
    logic       nat1_resend;
    logic [1:0] n;
    out_item_t  r0;
    out_item_t  r1;

    phase_next         = phase;
    retry_count_next   = retry_count;
    nat_kind_next      = nat_kind;
    binding_ip_next    = binding_ip;
    binding_port_next  = binding_port;
    server_b_ip_next   = server_b_ip;
    server_b_port_next = server_b_port;
    dual_port_a_next   = dual_port_a;
    dual_port_b_next   = dual_port_b;
    settle_req  = 1'b0;
    settle_t    = NAT_BLOCKED;
    rs_phase    = phase;
    rs_cnt      = retry_count;
    nat1_resend = 1'b0;
    n  = 2'd0;
    r0 = '0;
    r1 = '0;

    if (fire) begin
      case (s1.cmd)
        CMD_TICK_BINDING: begin
          n  = 2'd1;
          r0 = mk_request(REQ_BINDING, server_a_ip, server_a_port);
        end
        CMD_TICK_RESEND: begin
          if (phase == PH_NAT1) begin
            if (retry_count >= RETRY_LIMIT) begin
              // NAT1 exhausted: fall into NAT4 with a fresh count
              rs_phase         = PH_NAT4;
              rs_cnt           = '0;
              phase_next       = PH_NAT4;
              retry_count_next = '0;
            end else begin
              nat1_resend      = 1'b1;
              retry_count_next = retry_count + 3'd1;
              n  = 2'd1;
              r0 = mk_request(REQ_NAT1, server_a_ip, server_a_port);
            end
          end
          if (!nat1_resend) begin
            unique case (rs_phase)
              PH_SERVERB: begin
                if (rs_cnt >= RETRY_LIMIT) begin
                  settle_req = 1'b1;
                  settle_t   = NAT_BLOCKED;
                end else begin
                  retry_count_next = rs_cnt + 3'd1;
                  n  = 2'd1;
                  r0 = mk_request(REQ_SERVERB, server_a_ip, server_a_port);
                end
              end
              PH_NAT4: begin
                if (rs_cnt >= RETRY_LIMIT) begin
                  settle_req = 1'b1;
                  settle_t   = NAT_BLOCKED;
                end else begin
                  retry_count_next = rs_cnt + 3'd1;
                  if (dual_port_a == '0) begin
                    r0 = mk_request(REQ_NAT4, server_a_ip, server_a_port);
                    if (dual_port_b == '0) begin
                      r1 = mk_request(REQ_NAT4, server_b_ip, server_b_port);
                      n  = 2'd2;
                    end else begin
                      n = 2'd1;
                    end
                  end else if (dual_port_b == '0) begin
                    r0 = mk_request(REQ_NAT4, server_b_ip, server_b_port);
                    n  = 2'd1;
                  end
                end
              end
              PH_NAT2: begin
                if (rs_cnt >= RETRY_LIMIT) begin
                  settle_req = 1'b1;
                  settle_t   = NAT_PORT_RESTR;
                end else begin
                  retry_count_next = rs_cnt + 3'd1;
                  n  = 2'd1;
                  r0 = mk_request(REQ_NAT2, server_a_ip, server_a_port);
                end
              end
              default: begin
              end
            endcase
          end
        end
        CMD_TICK_RECHECK: begin
          if (phase >= PH_DONE && (nat_kind < NAT_OPEN || nat_kind > NAT_SYMMETRIC)) begin
            phase_next       = PH_SERVERB;
            retry_count_next = '0;
            dual_port_a_next = '0;
            dual_port_b_next = '0;
          end
        end
        CMD_RSP_BINDING: begin
          if (s1.parse_ok && (binding_ip != s1.mapped_ip || binding_port != s1.mapped_port))
          begin
            binding_ip_next   = s1.mapped_ip;
            binding_port_next = s1.mapped_port;
            r0 = mk_binding(s1.mapped_ip, s1.mapped_port);
            if (nat_kind != NAT_UNKNOWN) begin
              r1 = mk_report({2'b00, nat_kind} + NAT_PORT_CHANGE, server_a_ip, server_a_port);
              n  = 2'd2;
            end else begin
              n = 2'd1;
            end
          end
        end
        CMD_RSP_SERVERB: begin
          if (s1.parse_ok) begin
            server_b_ip_next   = s1.peer_b_ip;
            server_b_port_next = s1.peer_b_port;
            retry_count_next   = '0;
            phase_next         = PH_NAT1;
          end
        end
        CMD_RSP_NAT1: begin
          if (s1.parse_ok && s1.src_ip == server_b_ip) begin
            settle_req = 1'b1;
            settle_t   = NAT_OPEN;
          end
        end
        CMD_RSP_NAT4: begin
          if (s1.parse_ok) begin
            if (s1.src_ip == server_a_ip && s1.src_port == server_a_port) begin
              dual_port_a_next = s1.mapped_port;
            end
            if (s1.src_ip == server_b_ip && s1.src_port == server_b_port) begin
              dual_port_b_next = s1.mapped_port;
            end
            if (dual_port_a_next != '0 && dual_port_b_next != '0) begin
              if (dual_port_a_next != dual_port_b_next) begin
                settle_req = 1'b1;
                settle_t   = NAT_SYMMETRIC;
              end else begin
                retry_count_next = '0;
                phase_next       = PH_NAT2;
              end
            end
          end
        end
        CMD_RSP_NAT2: begin
          if (s1.parse_ok && s1.src_ip == server_a_ip) begin
            settle_req = 1'b1;
            settle_t   = NAT_RESTRICTED;
          end
        end
        default: begin
        end
      endcase

      // type settles once per probe run; a late blocked verdict stays silent
      if (settle_req && phase < PH_DONE) begin
        phase_next       = PH_DONE;
        retry_count_next = '0;
        if (nat_kind == NAT_UNKNOWN || settle_t != NAT_BLOCKED) begin
          nat_kind_next = settle_t;
          n  = 2'd2;
          r0 = mk_notice({2'b00, settle_t});
          r1 = mk_report({2'b00, settle_t}, server_a_ip, server_a_port);
        end
      end
    end

    r0.last    = (n == 2'd1);
    r1.last    = 1'b1;
    push.n     = n;
    push.item0 = r0;
    push.item1 = r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SERVERB;
      retry_count   <= '0;
      nat_kind      <= NAT_UNKNOWN;
      binding_ip    <= '0;
      binding_port  <= '0;
      server_b_ip   <= '0;
      server_b_port <= '0;
      dual_port_a   <= '0;
      dual_port_b   <= '0;
    end else begin
      phase         <= phase_next;
      retry_count   <= retry_count_next;
      nat_kind      <= nat_kind_next;
      binding_ip    <= binding_ip_next;
      binding_port  <= binding_port_next;
      server_b_ip   <= server_b_ip_next;
      server_b_port <= server_b_port_next;
      dual_port_a   <= dual_port_a_next;
      dual_port_b   <= dual_port_b_next;
    end
  end

  `NTP_ASSERT_HOLDS(a_retry_bound, clk, rst, retry_count <= RETRY_LIMIT, "retry count over limit")
  `NTP_ASSERT_IMPL(a_done_count, clk, rst, phase == PH_DONE, retry_count == '0, "count live when done")
  `NTP_ASSERT_NEXT(a_serverb_enter, clk, rst, fire && s1.cmd == CMD_RSP_SERVERB && s1.parse_ok, phase == PH_NAT1, "server-B response did not enter NAT1")

endmodule

`default_nettype wire

[src/ntp_resq.sv]
// Result queue: takes up to two result items per cycle, hands out one per cycle while res is taken.
// Depends on ntp_pkg, ntp_if and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "nat_type_probe_fsm_assert.svh"

module ntp_resq (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire ntp_pkg::push_t push,
  output logic                room,
  ntp_res_if.source           res
);
  import ntp_pkg::*;

  out_item_t            mem [RESQ_DEPTH];
  logic [RESQ_AW-1:0]   wp;
  logic [RESQ_AW-1:0]   rp;
  logic [RESQ_CW-1:0]   count;
  logic                 pop;
  out_item_t            head;

  assign room = count <= RESQ_CW'(RESQ_DEPTH - 2);
  assign pop  = res.valid && res.ready;
  assign head = mem[rp];

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wp] <= push.item0;
    end
    if (push.n == 2'd2) begin
      mem[wp + RESQ_AW'(1)] <= push.item1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + RESQ_AW'(push.n);
      rp    <= rp + RESQ_AW'(pop);
      count <= count + RESQ_CW'(push.n) - RESQ_CW'(pop);
    end
  end

  assign res.valid        = count != '0;
  assign res.kind         = head.kind;
  assign res.request_type = head.request_type;
  assign res.dest_ip      = head.dest_ip;
  assign res.dest_port    = head.dest_port;
  assign res.nat_code     = head.nat_code;
  assign res.bind_ip      = head.bind_ip;
  assign res.bind_port    = head.bind_port;
  assign res.last         = head.last;

  `NTP_ASSERT_HOLDS(a_count_bound, clk, rst, count <= RESQ_CW'(RESQ_DEPTH),
                    "queue count over depth")
  `NTP_ASSERT_IMPL(a_no_overflow, clk, rst, push.n != 2'd0,
                   count <= RESQ_CW'(RESQ_DEPTH - 2), "push without room")
  `NTP_ASSERT_NEXT(a_pop_drains, clk, rst, pop && push.n == 2'd0,
                   count == $past(count) - RESQ_CW'(1), "pop did not drain")

endmodule

`default_nettype wire
